FILE: rtl/core/modbus_frame_length_crc_checker_top_assert.svh
// Assertion macros for the modbus frame checker.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MODBUS_FRAME_LENGTH_CRC_CHECKER_TOP_ASSERT_SVH
`define MODBUS_FRAME_LENGTH_CRC_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MFCC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfcc check failed");

// Next-cycle implication, disabled during reset.
`define MFCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfcc check failed");

`endif

FILE: rtl/core/mfcc_pkg.sv
// Shared types, codes and the CRC-16/MODBUS byte update for the frame checker.
// No dependencies.
package mfcc_pkg;

  localparam int unsigned CountW = 17;

  typedef enum logic [2:0] {
    ST_NEED_MORE = 3'd0,
    ST_FRAME_OK  = 3'd1,
    ST_CRC_ERROR = 3'd2,
    ST_HEARTBEAT = 3'd3,
    ST_REG_OK    = 3'd4,
    ST_REG_BAD   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    KIND_RTU_DATA   = 2'd0,
    KIND_RTU_EXC    = 2'd1,
    KIND_WRITE_ECHO = 2'd2,
    KIND_TCP        = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [CountW-1:0] bytes_needed;
    kind_t             frame_kind;
  } res_t;

  localparam logic [CountW-1:0] COUNT_MAX = '1;
  localparam logic [CountW-1:0] REG_SIZE  = 17'd19;
  localparam logic [31:0]       TAG_REG   = 32'h4854_4C5A;  // "HTLZ"
  localparam logic [7:0]        HB_0      = 8'h4C;          // "LZH"
  localparam logic [7:0]        HB_1      = 8'h5A;
  localparam logic [7:0]        HB_2      = 8'h48;
  localparam logic [7:0]        FN_WRITE_COIL = 8'h05;
  localparam logic [7:0]        FN_WRITE_REG  = 8'h06;
  localparam logic [7:0]        FN_EXC_BASE   = 8'h80;
  localparam logic [15:0]       CRC_INIT  = 16'hFFFF;
  localparam logic [15:0]       CRC_POLY  = 16'hA001;

  // Reflected CRC-16/MODBUS, one byte (eight shift steps).
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/mfcc_channels.sv
// Channel interfaces for the frame checker: byte in, verdict out, mode write.
// Depends on mfcc_pkg.
interface mfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface mfcc_out_if;
  logic              valid;
  logic              ready;
  mfcc_pkg::status_t status;
  logic [16:0]       bytes_needed;
  mfcc_pkg::kind_t   frame_kind;
  modport source (output valid, output status, output bytes_needed, output frame_kind,
                  input ready);
  modport sink   (input valid, input status, input bytes_needed, input frame_kind,
                  output ready);
endinterface

interface mfcc_cfg_if;
  logic valid;
  logic ready;
  logic registration_mode;
  modport source (output valid, output registration_mode, input ready);
  modport sink   (input valid, input registration_mode, output ready);
endinterface

FILE: rtl/core/modbus_frame_length_crc_checker_top.sv
// Top level of the modbus frame length / CRC checker.
// Depends on mfcc_pkg, mfcc_channels, mfcc_core and the assertion macro header.
//
//   channel | dir | payload                                  | request
//   --------+-----+------------------------------------------+------------------------
//   rx      | in  | data_byte[7:0], frame_start               | one received byte
//   result  | out | status[2:0], bytes_needed[16:0], frame_kind | verdict for that byte
//   cfg     | in  | registration_mode                         | mode register write
//
// One request per clock sustained while result.ready stays high; every byte yields exactly one result.
// Each byte passes the input register, then classify/CRC into the result register.
// The per-byte CRC-16 update and the length compares sit between those two registers.
// rst is synchronous: frame state clears, CRC goes to 0xFFFF, mode goes to message mode.
// A stalled result holds the output register; the input register keeps one more byte,
// and rx.ready drops only when both are full and result.ready is low.
`include "modbus_frame_length_crc_checker_top_assert.svh"

module modbus_frame_length_crc_checker_top (
  input  logic         clk,
  input  logic         rst,
  mfcc_in_if.sink      rx,
  mfcc_out_if.source   result,
  mfcc_cfg_if.sink     cfg
);

  // Mode register, always ready; writes must arrive only while idle, which the block does not enforce.
  logic registration_mode;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      registration_mode <= 1'b0;
    end else if (cfg.valid) begin
      registration_mode <= cfg.registration_mode;
    end
  end

  // Input register stage.
  logic            s1_valid;
  mfcc_pkg::item_t s1_item;

  // Output register stage.
  logic            out_valid;
  mfcc_pkg::res_t  out_res;

  mfcc_pkg::res_t  core_res;
  logic            advance;   // s1 byte is classified and moves into the result register
  logic            rx_take;

  assign advance   = s1_valid && (!out_valid || result.ready);
  assign rx.ready  = !s1_valid || advance;
  assign rx_take   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      s1_item.data_byte   <= rx.data_byte;
      s1_item.frame_start <= rx.frame_start;
    end
  end

  // Frame state updates only when a byte leaves s1, keeping state in byte order.
  mfcc_core u_core (
    .clk               (clk),
    .rst               (rst),
    .step              (advance),
    .item              (s1_item),
    .registration_mode (registration_mode),
    .res               (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_res.status;
  assign result.bytes_needed = out_res.bytes_needed;
  assign result.frame_kind   = out_res.frame_kind;

  // A final verdict never carries a remaining byte count, and need-more always does.
  `MFCC_ASSERT_NOW(a_verdict_no_need, clk, rst,
    out_valid && out_res.status != mfcc_pkg::ST_NEED_MORE, out_res.bytes_needed == '0)
  `MFCC_ASSERT_NOW(a_need_nonzero, clk, rst,
    out_valid && out_res.status == mfcc_pkg::ST_NEED_MORE, out_res.bytes_needed != '0)
  // Heartbeat and registration verdicts report the default frame kind, KIND_RTU_DATA.
  `MFCC_ASSERT_NOW(a_kind_on_tagged, clk, rst,
    out_valid && (out_res.status == mfcc_pkg::ST_HEARTBEAT ||
    out_res.status == mfcc_pkg::ST_REG_OK || out_res.status == mfcc_pkg::ST_REG_BAD),
    out_res.frame_kind == mfcc_pkg::KIND_RTU_DATA)

endmodule

FILE: rtl/core/mfcc_core.sv
// Per-frame state (count, header, CRC, tag window) and byte classification.
// Depends on mfcc_pkg and the assertion macro header.
`include "modbus_frame_length_crc_checker_top_assert.svh"

module mfcc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  mfcc_pkg::item_t item,
  input  logic            registration_mode,
  output mfcc_pkg::res_t  res
);

  localparam int unsigned CW = mfcc_pkg::CountW;

  logic [CW-1:0] byte_count;
  logic [7:0]    header_bytes [6];
  logic [15:0]   crc_accum;
  logic [31:0]   tag_window;
  logic          tag_repeated;

  logic [CW-1:0] cnt_base, byte_count_next;
  logic [15:0]   crc_base, crc_accum_next;
  logic [31:0]   win_base, tag_window_next;
  logic          rep_base, tag_repeated_next;
  logic [7:0]    hdr_next [6];
  logic [CW-1:0] rtu_total, tcp_total;

  // frame_start wipes the running frame before this byte lands
  always_comb begin
    cnt_base = item.frame_start ? '0 : byte_count;
    crc_base = item.frame_start ? mfcc_pkg::CRC_INIT : crc_accum;
    win_base = item.frame_start ? '0 : tag_window;
    rep_base = item.frame_start ? 1'b0 : tag_repeated;
    for (int i = 0; i < 6; i++) begin
      hdr_next[i] = (cnt_base == CW'(i)) ? item.data_byte : header_bytes[i];
    end
    byte_count_next   = (cnt_base == mfcc_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
    crc_accum_next    = mfcc_pkg::crc_byte(crc_base, item.data_byte);
    tag_window_next   = {win_base[23:0], item.data_byte};
    tag_repeated_next = rep_base |
                        ((byte_count_next >= CW'(8)) && (tag_window_next == mfcc_pkg::TAG_REG));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      crc_accum    <= mfcc_pkg::CRC_INIT;
      tag_window   <= '0;
      tag_repeated <= 1'b0;
    end else if (step) begin
      byte_count   <= byte_count_next;
      crc_accum    <= crc_accum_next;
      tag_window   <= tag_window_next;
      tag_repeated <= tag_repeated_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 6; i++) begin
        header_bytes[i] <= hdr_next[i];
      end
    end
  end

  assign rtu_total = CW'({1'b0, hdr_next[2]}) + CW'(5);
  assign tcp_total = CW'(6) + CW'({hdr_next[4], hdr_next[5]});

  always_comb begin
    res.status       = mfcc_pkg::ST_NEED_MORE;
    res.bytes_needed = '0;
    res.frame_kind   = mfcc_pkg::KIND_RTU_DATA;
    if (registration_mode) begin
      if (byte_count_next < mfcc_pkg::REG_SIZE) begin
        res.bytes_needed = mfcc_pkg::REG_SIZE - byte_count_next;
      end else if ({hdr_next[0], hdr_next[1], hdr_next[2], hdr_next[3]} == mfcc_pkg::TAG_REG
                   && !tag_repeated_next) begin
        res.status = mfcc_pkg::ST_REG_OK;
      end else begin
        res.status = mfcc_pkg::ST_REG_BAD;
      end
    end else if (byte_count_next < CW'(3)) begin
      res.bytes_needed = CW'(3) - byte_count_next;
    end else if (hdr_next[0] == mfcc_pkg::HB_0 && hdr_next[1] == mfcc_pkg::HB_1 &&
                 hdr_next[2] == mfcc_pkg::HB_2) begin
      res.status = mfcc_pkg::ST_HEARTBEAT;
    end else if (hdr_next[1] == mfcc_pkg::FN_WRITE_COIL ||
                 hdr_next[1] == mfcc_pkg::FN_WRITE_REG) begin
      res.frame_kind = mfcc_pkg::KIND_WRITE_ECHO;
      if (byte_count_next < CW'(8)) begin
        res.bytes_needed = CW'(8) - byte_count_next;
      end else begin
        res.status = mfcc_pkg::ST_FRAME_OK;
      end
    end else if (hdr_next[2] != 8'h00) begin
      if (hdr_next[1] > mfcc_pkg::FN_EXC_BASE) begin
        res.frame_kind = mfcc_pkg::KIND_RTU_EXC;
        if (byte_count_next < CW'(5)) begin
          res.bytes_needed = CW'(5) - byte_count_next;
        end else if (byte_count_next == CW'(5) && crc_accum_next == 16'h0000) begin
          res.status = mfcc_pkg::ST_FRAME_OK;
        end else begin
          res.status = mfcc_pkg::ST_CRC_ERROR;  // bad CRC or overlong exception
        end
      end else if (byte_count_next < rtu_total) begin
        res.bytes_needed = rtu_total - byte_count_next;
      end else begin
        res.status = (crc_accum_next == 16'h0000) ? mfcc_pkg::ST_FRAME_OK
                                                  : mfcc_pkg::ST_CRC_ERROR;
      end
    end else begin
      res.frame_kind = mfcc_pkg::KIND_TCP;
      if (byte_count_next < CW'(7)) begin
        res.bytes_needed = CW'(7) - byte_count_next;
      end else if (byte_count_next < tcp_total) begin
        res.bytes_needed = tcp_total - byte_count_next;
      end else begin
        res.status = mfcc_pkg::ST_FRAME_OK;
      end
    end
  end

  `MFCC_ASSERT_NEXT(a_start_count_one, clk, rst, step && item.frame_start, byte_count == CW'(1))
  `MFCC_ASSERT_NEXT(a_idle_count_holds, clk, rst, !step, $stable(byte_count))
  `MFCC_ASSERT_NEXT(a_start_clears_tag, clk, rst, step && item.frame_start, !tag_repeated)

endmodule
